// ===== rtl/ptts_pkg.sv =====
package ptts_pkg;

   localparam int REQ_W   = 3;
   localparam int IDX_W   = 5;
   localparam int FIELD_W = 16;
   localparam int KIND_W  = 3;

   localparam logic [REQ_W-1:0] REQ_TICK     = 3'd0;
   localparam logic [REQ_W-1:0] REQ_CREATE   = 3'd1;
   localparam logic [REQ_W-1:0] REQ_DELETE   = 3'd2;
   localparam logic [REQ_W-1:0] REQ_SUSPEND  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_RESUME   = 3'd4;
   localparam logic [REQ_W-1:0] REQ_DISPATCH = 3'd5;

   localparam logic [KIND_W-1:0] KIND_DONE     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CREATED  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FULL     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DISPATCH = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NONE     = 3'd4;

   localparam logic [2:0] TC_NONE     = 3'd0;
   localparam logic [2:0] TC_TICK     = 3'd1;
   localparam logic [2:0] TC_CREATE   = 3'd2;
   localparam logic [2:0] TC_DELETE   = 3'd3;
   localparam logic [2:0] TC_SUSPEND  = 3'd4;
   localparam logic [2:0] TC_RESUME   = 3'd5;
   localparam logic [2:0] TC_DISPATCH = 3'd6;

   typedef struct packed {
      logic [2:0]         op;
      logic [IDX_W-1:0]   index;
      logic [FIELD_W-1:0] delay;
      logic [FIELD_W-1:0] period;
   } slot_cmd_type;

endpackage

// ===== rtl/ptts_req_if.sv =====
interface ptts_req_if;
   logic                            valid;
   logic                            ready;
   logic [ptts_pkg::REQ_W-1:0]      req_type;
   logic [ptts_pkg::IDX_W-1:0]      task_index;
   logic [ptts_pkg::FIELD_W-1:0]    start_delay;
   logic [ptts_pkg::FIELD_W-1:0]    period;

   modport source (output valid, output req_type, output task_index, output start_delay,
                   output period, input ready);
   modport sink (input valid, input req_type, input task_index, input start_delay,
                 input period, output ready);
endinterface

// ===== rtl/ptts_rsp_if.sv =====
interface ptts_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ptts_pkg::KIND_W-1:0]     result_kind;
   logic [ptts_pkg::IDX_W-1:0]      slot;
   logic                            was_one_shot;
   logic                            last;

   modport source (output valid, output result_kind, output slot, output was_one_shot,
                   output last, input ready);
   modport sink (input valid, input result_kind, input slot, input was_one_shot,
                 input last, output ready);
endinterface

// ===== rtl/ptts_slot_table.sv =====
module ptts_slot_table #(
   parameter int NUM_TASKS  = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ptts_pkg::slot_cmd_type cmd,
   output logic [NUM_TASKS-1:0]   used,
   output logic [NUM_TASKS-1:0]   qual,
   output logic                   period_zero
);

   localparam int SLOT_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

   logic [NUM_TASKS-1:0]  used_ff, used_in;
   logic [NUM_TASKS-1:0]  running_ff, running_in;
   logic [NUM_TASKS-1:0]  ready_ff, ready_in;
   logic [COUNT_BITS-1:0] cd_ff [NUM_TASKS];
   logic [COUNT_BITS-1:0] per_ff [NUM_TASKS];
   logic [COUNT_BITS-1:0] cd_in, per_in;
   logic                  cd_we, per_we;

   logic [SLOT_W-1:0]     sel;
   logic                  in_range;
   logic [COUNT_BITS-1:0] cur_cd, cur_per, base;

   assign sel      = cmd.index[SLOT_W-1:0];
   assign in_range = cmd.index < ptts_pkg::IDX_W'(NUM_TASKS);
   assign cur_cd   = cd_ff[sel];
   assign cur_per  = per_ff[sel];

   // shared reload/decrement unit
   assign base = (cur_cd == '0) ? cur_per : cur_cd;

   always_comb begin
      used_in    = used_ff;
      running_in = running_ff;
      ready_in   = ready_ff;
      cd_we      = 1'b0;
      per_we     = 1'b0;
      cd_in      = base - COUNT_BITS'(1);
      per_in     = COUNT_BITS'(cmd.period);
      if (in_range) begin
         case (cmd.op)
            ptts_pkg::TC_TICK: begin
               if (used_ff[sel]) begin
                  cd_we = 1'b1;
                  if (cur_cd == '0) begin
                     ready_in[sel] = 1'b1;
                  end
               end
            end
            ptts_pkg::TC_CREATE: begin
               used_in[sel]    = 1'b1;
               running_in[sel] = 1'b1;
               ready_in[sel]   = 1'b0;
               cd_we           = 1'b1;
               per_we          = 1'b1;
               cd_in           = COUNT_BITS'(cmd.delay);
            end
            ptts_pkg::TC_DELETE: begin
               used_in[sel]    = 1'b0;
               running_in[sel] = 1'b0;
               ready_in[sel]   = 1'b0;
            end
            ptts_pkg::TC_SUSPEND: begin
               running_in[sel] = 1'b0;
            end
            ptts_pkg::TC_RESUME: begin
               running_in[sel] = 1'b1;
            end
            ptts_pkg::TC_DISPATCH: begin
               ready_in[sel] = 1'b0;
               if (cur_per == '0) begin
                  used_in[sel]    = 1'b0;
                  running_in[sel] = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= '0;
         running_ff <= '0;
         ready_ff   <= '0;
      end else begin
         used_ff    <= used_in;
         running_ff <= running_in;
         ready_ff   <= ready_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cd_we) begin
         cd_ff[sel] <= cd_in;
      end
      if (per_we) begin
         per_ff[sel] <= per_in;
      end
   end

   assign used        = used_ff;
   assign qual        = ready_ff & running_ff;
   assign period_zero = (cur_per == '0);

endmodule

// ===== rtl/periodic_task_tick_scheduler_unit.sv =====
// channel   dir  handshake      payload
// req_bus   in   valid/ready    req_type, task_index, start_delay, period
// rsp_bus   out  valid/ready    result_kind, slot, was_one_shot, last
//
// tick and create walk the slot table one slot per cycle; create stops at the first free slot
// dispatch walks it the same way and emits one result per ready slot it passes
// delete, suspend, resume and nothing-ready dispatch skip the walk and go straight to the result state
// a full result register stalls the walk at the next slot that must emit
// synchronous reset frees every slot; no request is taken while an item is in progress
module periodic_task_tick_scheduler_unit #(
   parameter int NUM_TASKS  = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   ptts_req_if.sink  req_bus,
   ptts_rsp_if.source rsp_bus
);

   localparam int SLOT_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_TASKS - 1);
   localparam logic [ptts_pkg::IDX_W-1:0] NONE_SLOT = ptts_pkg::IDX_W'(NUM_TASKS);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]                     state_ff, state_in;
   logic [ptts_pkg::REQ_W-1:0]     op_ff, op_in;
   logic [ptts_pkg::FIELD_W-1:0]   delay_ff, delay_in;
   logic [ptts_pkg::FIELD_W-1:0]   period_ff, period_in;
   logic [SLOT_W-1:0]              cnt_ff, cnt_in;
   logic [ptts_pkg::KIND_W-1:0]    pend_kind_ff, pend_kind_in;
   logic [ptts_pkg::IDX_W-1:0]     pend_slot_ff, pend_slot_in;

   logic                           rsp_valid_ff;
   logic [ptts_pkg::KIND_W-1:0]    rsp_kind_ff;
   logic [ptts_pkg::IDX_W-1:0]     rsp_slot_ff;
   logic                           rsp_one_ff;
   logic                           rsp_last_ff;

   logic                           emit;
   logic [ptts_pkg::KIND_W-1:0]    emit_kind;
   logic [ptts_pkg::IDX_W-1:0]     emit_slot;
   logic                           emit_one;
   logic                           emit_last;

   ptts_pkg::slot_cmd_type         cmd;
   logic [NUM_TASKS-1:0]           used, qual;
   logic                           period_zero;
   logic                           rsp_free;
   logic                           more;

   ptts_slot_table #(
      .NUM_TASKS  (NUM_TASKS),
      .COUNT_BITS (COUNT_BITS)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .used        (used),
      .qual        (qual),
      .period_zero (period_zero)
   );

   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);

   // any ready slot above the current one
   always_comb begin
      more = 1'b0;
      for (int j = 0; j < NUM_TASKS; j++) begin
         if ((SLOT_W'(j) > cnt_ff) && qual[j]) begin
            more = 1'b1;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      delay_in     = delay_ff;
      period_in    = period_ff;
      cnt_in       = cnt_ff;
      pend_kind_in = pend_kind_ff;
      pend_slot_in = pend_slot_ff;
      emit         = 1'b0;
      emit_kind    = ptts_pkg::KIND_DONE;
      emit_slot    = '0;
      emit_one     = 1'b0;
      emit_last    = 1'b1;
      cmd.op       = ptts_pkg::TC_NONE;
      cmd.index    = ptts_pkg::IDX_W'(cnt_ff);
      cmd.delay    = delay_ff;
      cmd.period   = period_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               op_in        = req_bus.req_type;
               delay_in     = req_bus.start_delay;
               period_in    = req_bus.period;
               cnt_in       = '0;
               pend_kind_in = ptts_pkg::KIND_DONE;
               pend_slot_in = '0;
               cmd.index    = req_bus.task_index;
               state_in     = S_DONE;
               case (req_bus.req_type)
                  ptts_pkg::REQ_TICK,
                  ptts_pkg::REQ_CREATE: begin
                     state_in = S_SCAN;
                  end
                  ptts_pkg::REQ_DELETE: begin
                     cmd.op = ptts_pkg::TC_DELETE;
                  end
                  ptts_pkg::REQ_SUSPEND: begin
                     cmd.op = ptts_pkg::TC_SUSPEND;
                  end
                  ptts_pkg::REQ_RESUME: begin
                     cmd.op = ptts_pkg::TC_RESUME;
                  end
                  ptts_pkg::REQ_DISPATCH: begin
                     if (qual == '0) begin
                        pend_kind_in = ptts_pkg::KIND_NONE;
                        pend_slot_in = NONE_SLOT;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            case (op_ff)
               ptts_pkg::REQ_TICK: begin
                  cmd.op = ptts_pkg::TC_TICK;
                  if (cnt_ff == LAST_SLOT) begin
                     pend_kind_in = ptts_pkg::KIND_DONE;
                     pend_slot_in = '0;
                     state_in     = S_DONE;
                  end else begin
                     cnt_in = SLOT_W'(cnt_ff + 1'b1);
                  end
               end
               ptts_pkg::REQ_CREATE: begin
                  if (!used[cnt_ff]) begin
                     if (rsp_free) begin
                        cmd.op    = ptts_pkg::TC_CREATE;
                        emit      = 1'b1;
                        emit_kind = ptts_pkg::KIND_CREATED;
                        emit_slot = ptts_pkg::IDX_W'(cnt_ff);
                        state_in  = S_IDLE;
                     end
                  end else if (cnt_ff == LAST_SLOT) begin
                     pend_kind_in = ptts_pkg::KIND_FULL;
                     pend_slot_in = NONE_SLOT;
                     state_in     = S_DONE;
                  end else begin
                     cnt_in = SLOT_W'(cnt_ff + 1'b1);
                  end
               end
               default: begin
                  if (qual[cnt_ff]) begin
                     if (rsp_free) begin
                        cmd.op    = ptts_pkg::TC_DISPATCH;
                        emit      = 1'b1;
                        emit_kind = ptts_pkg::KIND_DISPATCH;
                        emit_slot = ptts_pkg::IDX_W'(cnt_ff);
                        emit_one  = period_zero;
                        emit_last = !more;
                        if (more) begin
                           cnt_in = SLOT_W'(cnt_ff + 1'b1);
                        end else begin
                           state_in = S_IDLE;
                        end
                     end
                  end else begin
                     cnt_in = SLOT_W'(cnt_ff + 1'b1);
                  end
               end
            endcase
         end
         S_DONE: begin
            if (rsp_free) begin
               emit      = 1'b1;
               emit_kind = pend_kind_ff;
               emit_slot = pend_slot_ff;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      delay_ff     <= delay_in;
      period_ff    <= period_in;
      cnt_ff       <= cnt_in;
      pend_kind_ff <= pend_kind_in;
      pend_slot_ff <= pend_slot_in;
      if (emit) begin
         rsp_kind_ff <= emit_kind;
         rsp_slot_ff <= emit_slot;
         rsp_one_ff  <= emit_one;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.result_kind  = rsp_kind_ff;
   assign rsp_bus.slot         = rsp_slot_ff;
   assign rsp_bus.was_one_shot = rsp_one_ff;
   assign rsp_bus.last         = rsp_last_ff;

endmodule
